// ----- hdl/kss_pkg.sv -----
// ----------------------------------------------------------------------------
// kss_pkg
// Shared constants, codes and control types of the keyframe sprite sequencer.
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int MAX_FRAMES  = 64;
  localparam int COORD_BITS  = 12;
  localparam int ADDR_W      = $clog2(MAX_FRAMES);
  localparam int COUNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int TIME_W      = 32;
  localparam int DELTA_W     = 20;
  localparam int SPEED_W     = 16;
  localparam int RECT_W      = 4 * COORD_BITS;
  localparam int INDEX_W     = 6;
  localparam int PROD_W      = DELTA_W + 1 + SPEED_W;
  localparam int STEP_SHIFT  = 8;
  localparam int SUM_W       = TIME_W + 2;
  localparam int DIV_STEPS   = SUM_W;
  localparam int DCNT_W      = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED  = 2'd0,
    REG_LOOP   = 2'd1,
    REG_PAUSE  = 2'd2,
    REG_FCOUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_FOLD,
    S_DIV,
    S_FIXUP,
    S_SCAN,
    S_RECT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept_tick;
    logic accept_load;
    logic mul;
    logic sum;
    logic fold;
    logic div_step;
    logic fixup;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic paused;
    logic need_div;
    logic div_last;
    logic scan_hit;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ----- hdl/kss_ctrl.sv -----
// ----------------------------------------------------------------------------
// kss_ctrl
// Sequencing state machine: steps one item through multiply, range fold,
// remainder, frame scan, rectangle read and output load.
// ----------------------------------------------------------------------------
module kss_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   command,
  output logic                   in_stall,
  input  kss_pkg::ctrl_stat_t    stat,
  output kss_pkg::ctrl_cmd_t     cmd
);

  kss_pkg::state_t state;
  kss_pkg::state_t state_next;
  logic            accept;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != kss_pkg::S_IDLE);
    case (state)
      kss_pkg::S_IDLE: begin
        if (accept) begin
          if (command == kss_pkg::CMD_LOAD) begin
            cmd.accept_load = 1'b1;
          end else begin
            cmd.accept_tick = 1'b1;
            // no entries in use: the tick is dropped
            if (stat.count_zero) begin
              state_next = kss_pkg::S_IDLE;
            end else if (stat.paused) begin
              state_next = kss_pkg::S_RECT;
            end else begin
              state_next = kss_pkg::S_MUL;
            end
          end
        end
      end
      kss_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = kss_pkg::S_SUM;
      end
      kss_pkg::S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = kss_pkg::S_FOLD;
      end
      kss_pkg::S_FOLD: begin
        cmd.fold = 1'b1;
        if (stat.need_div) begin
          state_next = kss_pkg::S_DIV;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = kss_pkg::S_SCAN;
        end
      end
      kss_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = kss_pkg::S_FIXUP;
        end
      end
      kss_pkg::S_FIXUP: begin
        cmd.fixup      = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = kss_pkg::S_SCAN;
      end
      kss_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          state_next = kss_pkg::S_RECT;
        end
      end
      kss_pkg::S_RECT: begin
        state_next = kss_pkg::S_OUT;
      end
      kss_pkg::S_OUT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = kss_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/kss_dp.sv -----
// ----------------------------------------------------------------------------
// kss_dp
// Datapath: configuration registers, keyframe memories, step multiplier,
// range fold, restoring remainder unit, frame scan and output register.
// ----------------------------------------------------------------------------
module kss_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  kss_pkg::ctrl_cmd_t                  cmd,
  output kss_pkg::ctrl_stat_t                 stat,
  input  logic                                cfg_valid,
  input  logic [kss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [kss_pkg::DELTA_W-1:0]         delta,
  input  logic [kss_pkg::INDEX_W-1:0]         entry_index,
  input  logic [kss_pkg::TIME_W-1:0]          entry_time,
  input  logic [kss_pkg::COORD_BITS-1:0]      entry_x,
  input  logic [kss_pkg::COORD_BITS-1:0]      entry_y,
  input  logic [kss_pkg::COORD_BITS-1:0]      entry_w,
  input  logic [kss_pkg::COORD_BITS-1:0]      entry_h,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [kss_pkg::INDEX_W-1:0]         frame_number,
  output logic [kss_pkg::COORD_BITS-1:0]      rect_x,
  output logic [kss_pkg::COORD_BITS-1:0]      rect_y,
  output logic [kss_pkg::COORD_BITS-1:0]      rect_w,
  output logic [kss_pkg::COORD_BITS-1:0]      rect_h,
  output logic [kss_pkg::TIME_W-1:0]          time_now
);

  localparam int CB = kss_pkg::COORD_BITS;

  // configuration
  logic signed [kss_pkg::SPEED_W-1:0] speed;
  logic                               loop_enable;
  logic                               pause;
  logic [kss_pkg::COUNT_W-1:0]        frame_count;

  // keyframe memories
  logic [kss_pkg::TIME_W-1:0] frame_times [kss_pkg::MAX_FRAMES];
  logic [kss_pkg::RECT_W-1:0] frame_rects [kss_pkg::MAX_FRAMES];
  logic [kss_pkg::TIME_W-1:0] rd_time;
  logic [kss_pkg::RECT_W-1:0] rd_rect;
  logic [kss_pkg::ADDR_W-1:0] taddr;
  logic                       load_we;

  // arithmetic state
  logic [kss_pkg::DELTA_W-1:0]       delta_r;
  logic signed [kss_pkg::PROD_W-1:0] product;
  logic [kss_pkg::TIME_W-1:0]        total;
  logic signed [kss_pkg::SUM_W-1:0]  sum_v;
  logic signed [kss_pkg::SUM_W-1:0]  sum_v_next;
  logic [kss_pkg::SUM_W-1:0]         dividend;
  logic [kss_pkg::TIME_W-1:0]        rem;
  logic [kss_pkg::TIME_W:0]          trial;
  logic [kss_pkg::DCNT_W-1:0]        div_cnt;
  logic [kss_pkg::TIME_W-1:0]        elapsed;
  logic [kss_pkg::ADDR_W-1:0]        current_frame;

  // scan pipeline
  logic [kss_pkg::ADDR_W-1:0]  cmp_idx;
  logic                        cmp_v;
  logic [kss_pkg::COUNT_W-1:0] n_used;
  logic [kss_pkg::ADDR_W-1:0]  n_last;
  logic                        time_over;

  logic v_neg;
  logic v_ge_total;
  logic in_range;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      speed       <= kss_pkg::SPEED_W'(256);
      loop_enable <= 1'b0;
      pause       <= 1'b0;
      frame_count <= '0;
    end else if (cfg_valid) begin
      case (kss_pkg::cfg_reg_t'(cfg_index))
        kss_pkg::REG_SPEED:  speed       <= signed'(cfg_data[kss_pkg::SPEED_W-1:0]);
        kss_pkg::REG_LOOP:   loop_enable <= cfg_data[0];
        kss_pkg::REG_PAUSE:  pause       <= cfg_data[0];
        kss_pkg::REG_FCOUNT: frame_count <= cfg_data[kss_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_used = (frame_count > kss_pkg::COUNT_W'(kss_pkg::MAX_FRAMES))
                ? kss_pkg::COUNT_W'(kss_pkg::MAX_FRAMES) : frame_count;
  assign n_last = kss_pkg::ADDR_W'(n_used - kss_pkg::COUNT_W'(1));

  // ---------------------------------------------------------------- memories
  assign load_we = cmd.accept_load &&
                   (int'(entry_index) < kss_pkg::MAX_FRAMES);

  always_ff @(posedge clk) begin
    if (load_we) begin
      frame_times[entry_index[kss_pkg::ADDR_W-1:0]] <= entry_time;
      frame_rects[entry_index[kss_pkg::ADDR_W-1:0]] <= {entry_x, entry_y, entry_w, entry_h};
    end
    rd_time <= frame_times[taddr];
    rd_rect <= frame_rects[current_frame];
  end

  // ---------------------------------------------------------------- step and fold
  assign sum_v_next = signed'({2'b00, elapsed}) +
                      kss_pkg::SUM_W'(product >>> kss_pkg::STEP_SHIFT);

  assign v_neg      = sum_v[kss_pkg::SUM_W-1];
  assign v_ge_total = !v_neg &&
                      (sum_v[kss_pkg::SUM_W-2:0] >= {1'b0, total});
  assign in_range   = !v_neg && !v_ge_total;

  assign trial     = {rem, dividend[kss_pkg::SUM_W-1]};
  assign time_over = rd_time > elapsed;

  always_ff @(posedge clk) begin
    if (cmd.accept_tick) begin
      delta_r <= delta;
    end
    if (cmd.mul) begin
      product <= signed'({1'b0, delta_r}) * speed;
    end
    if (cmd.sum) begin
      total <= rd_time;
      sum_v <= sum_v_next;
    end
    if (cmd.fold) begin
      dividend <= v_neg ? kss_pkg::SUM_W'(-sum_v) : kss_pkg::SUM_W'(sum_v);
      rem      <= '0;
    end
    if (cmd.div_step) begin
      // one restoring step per cycle
      if (trial >= {1'b0, total}) begin
        rem <= kss_pkg::TIME_W'(trial - {1'b0, total});
      end else begin
        rem <= trial[kss_pkg::TIME_W-1:0];
      end
      dividend <= {dividend[kss_pkg::SUM_W-2:0], 1'b0};
    end
    if (cmd.scan_step) begin
      cmp_idx <= taddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed       <= '0;
      current_frame <= '0;
      div_cnt       <= '0;
      taddr         <= '0;
      cmp_v         <= 1'b0;
    end else begin
      if (cmd.accept_tick) begin
        taddr <= n_last;
      end
      if (cmd.fold) begin
        div_cnt <= kss_pkg::DCNT_W'(kss_pkg::DIV_STEPS);
        if (in_range) begin
          elapsed <= sum_v[kss_pkg::TIME_W-1:0];
        end else if (!loop_enable) begin
          elapsed <= v_neg ? '0 : total;
        end else if (total == '0) begin
          elapsed <= '0;
        end
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt - kss_pkg::DCNT_W'(1);
      end
      if (cmd.fixup) begin
        // floor modulo: negative sums fold back from the top
        elapsed <= (v_neg && rem != '0) ? total - rem : rem;
      end
      if (cmd.scan_start) begin
        taddr <= '0;
        cmp_v <= 1'b0;
      end
      if (cmd.scan_step) begin
        taddr <= taddr + kss_pkg::ADDR_W'(1);
        cmp_v <= 1'b1;
        if (cmp_v) begin
          if (time_over) begin
            current_frame <= (cmp_idx == '0) ? '0 : cmp_idx - kss_pkg::ADDR_W'(1);
          end else if (cmp_idx == n_last) begin
            current_frame <= n_last;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      frame_number <= kss_pkg::INDEX_W'(current_frame);
      rect_x       <= rd_rect[4*CB-1:3*CB];
      rect_y       <= rd_rect[3*CB-1:2*CB];
      rect_w       <= rd_rect[2*CB-1:CB];
      rect_h       <= rd_rect[CB-1:0];
      time_now     <= elapsed;
    end
  end

  // ---------------------------------------------------------------- status
  always_comb begin
    stat.count_zero = (n_used == '0);
    stat.paused     = pause;
    stat.need_div   = !in_range && loop_enable && (total != '0);
    stat.div_last   = (div_cnt == kss_pkg::DCNT_W'(1));
    stat.scan_hit   = cmp_v && (time_over || cmp_idx == n_last);
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

// ----- hdl/keyframe_sprite_sequencer.sv -----
// ----------------------------------------------------------------------------
// keyframe_sprite_sequencer
// Sprite animation frame lookup over a table of timed keyframes.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a word with command = load writes one
// keyframe entry (start time and rectangle) and yields no result. A word with
// command = tick advances elapsed time by delta * speed (unless paused),
// clamps or wraps it around the last entry's time, picks the current keyframe
// and yields one result word on the output channel (out_valid / out_stall).
// With a frame count of zero a tick yields nothing. A running tick scans
// entries one a cycle from entry 0 until the first later start time, at most
// the frame count; a wrap that needs a remainder first runs through the
// one-bit-per-cycle restoring unit. A paused tick skips arithmetic and scan.
// One item is worked at a time; in_stall is high until it finishes.
// The output register holds a finished word while out_stall is high, and
// the next item may be accepted meanwhile; its result waits for the register.
// Configuration (cfg_valid / cfg_ready) is always ready; the user must write
// it only while idle, which the block itself does not enforce. Synchronous
// reset clears elapsed time, current frame, control state and out_valid and
// resets the configuration; keyframe entries are undefined until loaded.
// ----------------------------------------------------------------------------
module keyframe_sprite_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [kss_pkg::DELTA_W-1:0]       delta,
  input  logic [kss_pkg::INDEX_W-1:0]       entry_index,
  input  logic [kss_pkg::TIME_W-1:0]        entry_time,
  input  logic [kss_pkg::COORD_BITS-1:0]    entry_x,
  input  logic [kss_pkg::COORD_BITS-1:0]    entry_y,
  input  logic [kss_pkg::COORD_BITS-1:0]    entry_w,
  input  logic [kss_pkg::COORD_BITS-1:0]    entry_h,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kss_pkg::INDEX_W-1:0]       frame_number,
  output logic [kss_pkg::COORD_BITS-1:0]    rect_x,
  output logic [kss_pkg::COORD_BITS-1:0]    rect_y,
  output logic [kss_pkg::COORD_BITS-1:0]    rect_w,
  output logic [kss_pkg::COORD_BITS-1:0]    rect_h,
  output logic [kss_pkg::TIME_W-1:0]        time_now,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  kss_pkg::ctrl_cmd_t  cmd;
  kss_pkg::ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  kss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kss_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .delta        (delta),
    .entry_index  (entry_index),
    .entry_time   (entry_time),
    .entry_x      (entry_x),
    .entry_y      (entry_y),
    .entry_w      (entry_w),
    .entry_h      (entry_h),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .frame_number (frame_number),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_w       (rect_w),
    .rect_h       (rect_h),
    .time_now     (time_now)
  );

endmodule

// ----- bench/tb_keyframe_sprite_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_sprite_sequencer
// Self-checking bench for the keyframe sprite sequencer. Loads keyframe tables
// and sends time ticks under many playback settings. A scoreboard tracks the
// elapsed time and the shown frame, and predicts every result word. The run
// starts with a directed set of corner cases, then moves to random phases with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_keyframe_sprite_sequencer;

  localparam int  LIMIT_CYCLES = 1_000_000;
  localparam int  DRAIN_CYCLES = 120;   // worst tick: full scan plus remainder
  localparam int  HOLD_CYCLES  = 600;
  localparam int  RANDOM_WORDS = 1000;
  localparam longint TIME_TOP  = 64'h0000_0000_FFFF_FFFF;

  typedef logic [kss_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x, y, w, h;
  } sprite_rect_t;

  typedef struct {
    logic [kss_pkg::INDEX_W-1:0] frame;
    coord_t                      x, y, w, h;
    logic [kss_pkg::TIME_W-1:0]  t;
  } sprite_word_t;

  // Tracks playback state and holds the frame words still owed by the block.
  class keyframe_tracker;
    logic [kss_pkg::TIME_W-1:0]         key_time [kss_pkg::MAX_FRAMES];
    sprite_rect_t                       key_rect [kss_pkg::MAX_FRAMES];
    logic [kss_pkg::TIME_W-1:0]         play_time;
    logic [kss_pkg::INDEX_W-1:0]        shown_frame;
    logic signed [kss_pkg::SPEED_W-1:0] rate;
    logic                               wrap_on;
    logic                               frozen;
    logic [kss_pkg::COUNT_W-1:0]        used_count;
    sprite_word_t                       due_frames[$];
    int                                 errors;
    int                                 checked;
    int                                 wraps;
    int                                 clamps;

    function new();
      play_time   = '0;
      shown_frame = '0;
      rate        = 16'sd256;
      wrap_on     = 1'b0;
      frozen      = 1'b0;
      used_count  = '0;
      errors      = 0;
      checked     = 0;
      wraps       = 0;
      clamps      = 0;
    endfunction

    function void set_reg(kss_pkg::cfg_reg_t idx, logic [kss_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        kss_pkg::REG_SPEED:  rate = data;
        kss_pkg::REG_LOOP:   wrap_on = data[0];
        kss_pkg::REG_PAUSE:  frozen = data[0];
        kss_pkg::REG_FCOUNT: used_count = data[kss_pkg::COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(logic cmd, logic [kss_pkg::DELTA_W-1:0] dl,
                            logic [kss_pkg::INDEX_W-1:0] idx,
                            logic [kss_pkg::TIME_W-1:0] at, sprite_rect_t r);
      int           n;
      int           i;
      longint       step;
      longint       sum;
      longint       total;
      longint       m;
      sprite_word_t w;
      if (cmd == kss_pkg::CMD_LOAD) begin
        key_time[idx] = at;
        key_rect[idx] = r;
      end else begin
        n = (used_count > kss_pkg::MAX_FRAMES) ? kss_pkg::MAX_FRAMES : int'(used_count);
        if (n != 0) begin
          if (!frozen) begin
            // Q4.16 times Q8.8, floored back to Q16.16
            step  = (longint'(dl) * longint'(rate)) >>> kss_pkg::STEP_SHIFT;
            sum   = longint'(play_time) + step;
            total = longint'(key_time[n-1]);
            if (sum < 0 || sum >= total) begin
              if (!wrap_on) begin
                clamps++;
                sum = (sum < 0) ? 0 : total;
              end else begin
                wraps++;
                if (total == 0) begin
                  sum = 0;
                end else begin
                  m = sum % total;
                  if (m < 0) m += total;
                  sum = m;
                end
              end
            end
            play_time = sum[kss_pkg::TIME_W-1:0];
            i = 0;
            while (i < n && key_time[i] <= play_time) i++;
            shown_frame = kss_pkg::INDEX_W'((i == 0) ? 0 : i - 1);
          end
          w.frame = shown_frame;
          w.x     = key_rect[shown_frame].x;
          w.y     = key_rect[shown_frame].y;
          w.w     = key_rect[shown_frame].w;
          w.h     = key_rect[shown_frame].h;
          w.t     = play_time;
          due_frames.push_back(w);
        end
      end
    endfunction

    function void match(string what, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_word(sprite_word_t got);
      sprite_word_t want;
      if (due_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual frame %0d time %0h",
                 $time, got.frame, got.t);
      end else begin
        want = due_frames.pop_front();
        checked++;
        match("frame_number", want.frame, got.frame);
        match("rect_x", want.x, got.x);
        match("rect_y", want.y, got.y);
        match("rect_w", want.w, got.w);
        match("rect_h", want.h, got.h);
        match("time_now", want.t, got.t);
      end
    endfunction
  endclass

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           in_valid    = 1'b0;
  logic                           in_stall;
  logic                           command     = kss_pkg::CMD_TICK;
  logic [kss_pkg::DELTA_W-1:0]    delta       = '0;
  logic [kss_pkg::INDEX_W-1:0]    entry_index = '0;
  logic [kss_pkg::TIME_W-1:0]     entry_time  = '0;
  coord_t                         entry_x     = '0;
  coord_t                         entry_y     = '0;
  coord_t                         entry_w     = '0;
  coord_t                         entry_h     = '0;
  logic                           out_valid;
  logic                           out_stall   = 1'b0;
  logic [kss_pkg::INDEX_W-1:0]    frame_number;
  coord_t                         rect_x;
  coord_t                         rect_y;
  coord_t                         rect_w;
  coord_t                         rect_h;
  logic [kss_pkg::TIME_W-1:0]     time_now;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready;
  kss_pkg::cfg_reg_t              cfg_index   = kss_pkg::REG_SPEED;
  logic [kss_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

  keyframe_tracker tracker = new();

  int  cycle_count  = 0;
  int  words_sent   = 0;
  int  loads_sent   = 0;
  int  ticks_sent   = 0;
  int  phase_no     = 0;
  int  hold_left    = 0;
  bit  calm         = 1'b0;
  bit  hold_request = 1'b0;

  keyframe_sprite_sequencer u_dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("keyframe_sprite_sequencer test failed");
    $finish;
  end

  // Output side: check each accepted word, then pick the next stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        tracker.check_word('{frame_number, rect_x, rect_y, rect_w, rect_h, time_now});
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 28);
      end
    end
  end

  function automatic sprite_rect_t any_rect();
    sprite_rect_t r;
    r.x = coord_t'($urandom);
    r.y = coord_t'($urandom);
    r.w = coord_t'($urandom);
    r.h = coord_t'($urandom);
    return r;
  endfunction

  task automatic put_word(logic cmd, logic [kss_pkg::DELTA_W-1:0] dl,
                          logic [kss_pkg::INDEX_W-1:0] idx,
                          logic [kss_pkg::TIME_W-1:0] at, sprite_rect_t r);
    cfg_valid <= 1'b0;
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    delta       <= dl;
    entry_index <= idx;
    entry_time  <= at;
    entry_x     <= r.x;
    entry_y     <= r.y;
    entry_w     <= r.w;
    entry_h     <= r.h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_word(cmd, dl, idx, at, r);
    words_sent++;
    if (cmd == kss_pkg::CMD_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  task automatic put_tick(logic [kss_pkg::DELTA_W-1:0] dl);
    put_word(kss_pkg::CMD_TICK, dl, kss_pkg::INDEX_W'($urandom),
             kss_pkg::TIME_W'($urandom), any_rect());
  endtask

  task automatic put_load(logic [kss_pkg::INDEX_W-1:0] idx, logic [kss_pkg::TIME_W-1:0] at,
                          sprite_rect_t r);
    put_word(kss_pkg::CMD_LOAD, kss_pkg::DELTA_W'($urandom), idx, at, r);
  endtask

  // Leaves cfg_valid high; the next word or settle drops it.
  task automatic write_reg(kss_pkg::cfg_reg_t idx, logic [kss_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  // Wait out every owed word, then let a tick that yields nothing finish too.
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int words, bit full);
    int                           n_cfg;
    int                           n_load;
    int                           span;
    int                           bits;
    int                           pick;
    longint                       at;
    logic [kss_pkg::SPEED_W-1:0]  rate;
    logic [kss_pkg::DELTA_W-1:0]  dl;
    case ($urandom_range(9))
      0:       rate = 16'h8000;
      1:       rate = 16'h7FFF;
      2:       rate = 16'h0000;
      3:       rate = 16'h0100;
      4, 5:    rate = 16'($urandom_range(1, 1024));
      6:       rate = 16'(0 - int'($urandom_range(1, 1024)));
      default: rate = 16'($urandom);
    endcase
    if (phase_no % 7 == 6) begin
      n_cfg = 0;
    end else begin
      case ($urandom_range(9))
        0:       n_cfg = 64 + $urandom_range(1, 63);
        1:       n_cfg = 64;
        2:       n_cfg = 1;
        default: n_cfg = $urandom_range(2, 64);
      endcase
    end
    write_reg(kss_pkg::REG_SPEED, rate);
    write_reg(kss_pkg::REG_LOOP, 16'($urandom_range(1)));
    write_reg(kss_pkg::REG_PAUSE, 16'($urandom_range(99) < 15));
    write_reg(kss_pkg::REG_FCOUNT, 16'(n_cfg));

    // Rewrite the table prefix in ascending order, duplicates allowed.
    if (full || $urandom_range(99) < 60) begin
      n_load = full ? kss_pkg::MAX_FRAMES
                    : ((n_cfg == 0) ? 1 : ((n_cfg > 64) ? 64 : n_cfg));
      span   = 1 << $urandom_range(6, 26);
      at     = $urandom_range(1) ? 0 : $urandom_range(0, span);
      for (int i = 0; i < n_load; i++) begin
        put_load(kss_pkg::INDEX_W'(i), kss_pkg::TIME_W'(at), any_rect());
        at += ($urandom_range(9) == 0) ? 0 : $urandom_range(0, span);
        if (at > TIME_TOP) at = TIME_TOP;
      end
    end

    if (phase_no == 2) hold_request = 1'b1;

    for (int k = 0; k < words; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // stray load anywhere in the table, order not kept
        put_load(kss_pkg::INDEX_W'($urandom), kss_pkg::TIME_W'($urandom), any_rect());
      end else begin
        bits = $urandom_range(1, kss_pkg::DELTA_W);
        if (pick < 12) dl = '0;
        else if (pick < 16) dl = '1;
        else dl = kss_pkg::DELTA_W'($urandom_range(0, (1 << bits) - 1));
        put_tick(dl);
      end
    end
  endtask

  initial begin
    int first_random;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No frames in use: ticks yield nothing.
    put_tick('1);
    put_tick('0);
    put_load(6'd0, 32'h0000_0000, '{12'h000, 12'h000, 12'h000, 12'h000});
    put_load(6'd1, 32'h0001_0000, '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    put_load(6'd2, 32'h0002_0000, '{12'hABC, 12'h543, 12'h00F, 12'hF00});
    put_load(6'd63, 32'hFFFF_FFFF, '{12'h5A5, 12'hA5A, 12'h123, 12'hEDC});
    settle();
    write_reg(kss_pkg::REG_FCOUNT, 16'd3);
    put_tick('0);
    put_tick(20'h10000);
    put_tick('1);                    // clamp at the last frame's time
    settle();
    write_reg(kss_pkg::REG_SPEED, 16'h8000);
    put_tick(20'h10000);             // clamp at zero
    settle();
    write_reg(kss_pkg::REG_LOOP, 16'd1);
    write_reg(kss_pkg::REG_SPEED, 16'h7FFF);
    put_tick(20'h00100);
    put_tick('1);                    // wrap forward
    settle();
    write_reg(kss_pkg::REG_SPEED, 16'h8000);
    put_tick(20'h0C001);             // wrap below zero
    settle();
    write_reg(kss_pkg::REG_SPEED, 16'h0100);
    put_tick(kss_pkg::DELTA_W'(32'h0002_0000 - tracker.play_time));   // land on total, wrap
    settle();
    write_reg(kss_pkg::REG_LOOP, 16'd0);
    put_tick(kss_pkg::DELTA_W'(32'h0002_0000 - tracker.play_time));   // land on total, hold
    settle();
    write_reg(kss_pkg::REG_PAUSE, 16'd1);
    put_tick('1);
    put_load(6'd2, 32'h0002_0000, '{12'h321, 12'h654, 12'h987, 12'hCBA});
    put_tick(20'h12345);             // frozen frame shows its reloaded rectangle
    settle();
    write_reg(kss_pkg::REG_PAUSE, 16'd0);
    write_reg(kss_pkg::REG_FCOUNT, 16'd1);
    write_reg(kss_pkg::REG_SPEED, 16'h0000);
    put_tick('1);
    settle();
    write_reg(kss_pkg::REG_SPEED, 16'h0100);
    write_reg(kss_pkg::REG_LOOP, 16'd1);
    put_tick(20'h00005);             // zero total with looping
    settle();
    write_reg(kss_pkg::REG_LOOP, 16'd0);
    put_tick(20'h00005);             // zero total with clamping
    settle();

    first_random = words_sent;
    while (words_sent - first_random < RANDOM_WORDS) begin
      calm = (phase_no == 4);
      random_phase(calm ? 150 : ((phase_no == 2) ? 80 : 30 + $urandom_range(40)),
                   phase_no == 0);
      settle();
      phase_no++;
    end
    calm = 1'b0;

    $display("Sent %0d words (%0d loads, %0d ticks) over %0d random phases.",
             words_sent, loads_sent, ticks_sent, phase_no);
    $display("Checked %0d frame words; %0d wraps and %0d clamps predicted.",
             tracker.checked, tracker.wraps, tracker.clamps);
    if (tracker.errors == 0 && tracker.due_frames.size() == 0) begin
      $display("keyframe_sprite_sequencer test passed");
    end else begin
      $display("keyframe_sprite_sequencer test failed");
    end
    $finish;
  end

endmodule

// ----- keyframe_sprite_sequencer.f -----
hdl/kss_pkg.sv
hdl/kss_ctrl.sv
hdl/kss_dp.sv
hdl/keyframe_sprite_sequencer.sv
bench/tb_keyframe_sprite_sequencer.sv
